>>> hw/rtl/digit_trie_prefix_checker_macros.svh
// assertion macros shared by the digit trie prefix checker rtl
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef DIGIT_TRIE_PREFIX_CHECKER_MACROS_SVH
`define DIGIT_TRIE_PREFIX_CHECKER_MACROS_SVH
`ifndef SYNTHESIS
`define DTP_ASSERT_NOW(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dtp check failed");
`define DTP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtp check failed");
`else
`define DTP_ASSERT_NOW(lbl, cond)
`define DTP_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/dtp_pkg.sv
// types, constants and helpers of the digit trie prefix checker
// no dependencies
package dtp_pkg;

    localparam int RADIX      = 10;
    localparam int DIGIT_W    = 4;
    localparam int STR_W      = 40;
    localparam int CNT_W      = 4;
    localparam int STR_DIGITS = STR_W / DIGIT_W;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    typedef struct packed {
        logic             clear;
        logic [STR_W-1:0] digits;
        logic [CNT_W-1:0] count;
    } cmd_t;

    typedef struct packed {
        logic conflict;
        logic any_conflict;
        logic table_full;
    } res_t;

    typedef enum logic {
        ENG_IDLE,
        ENG_WALK
    } eng_state_t;

    // clamp a bcd nibble to nine
    function automatic logic [DIGIT_W-1:0] sat_digit(input logic [DIGIT_W-1:0] nib);
        return (nib > 4'd9) ? 4'd9 : nib;
    endfunction

    // digit at a position; positions past the string read as zero
    function automatic logic [DIGIT_W-1:0] digit_at(input logic [STR_W-1:0] s,
                                                    input logic [CNT_W-1:0] pos);
        logic [DIGIT_W-1:0] d;
        d = '0;
        if (pos < CNT_W'(STR_DIGITS))
        begin
            d = s[{pos, 2'b00} +: DIGIT_W];
        end
        return d;
    endfunction

endpackage

>>> hw/rtl/dtp_front.sv
// front end: accepts requests, normalises digits and count, queues commands
// depends on dtp_pkg
module dtp_front #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic                     req_type,
    input  logic [dtp_pkg::STR_W-1:0] digit_string,
    input  logic [dtp_pkg::CNT_W-1:0] num_digits,
    output logic                     cmd_valid,
    output dtp_pkg::cmd_t            cmd,
    input  logic                     cmd_pop
);
    import dtp_pkg::*;

    localparam logic [CNT_W:0] MAXD = (CNT_W+1)'(MAX_DIGITS);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cls;
    logic [CNT_W-1:0] n;
    logic       wr_en;

    // classify the incoming transaction
    always_comb
    begin
        n = (num_digits == '0) ? CNT_W'(1) : num_digits;
        if ({1'b0, n} > MAXD)
        begin
            n = MAXD[CNT_W-1:0];
        end
        cls.clear = (req_type == REQ_CLEAR);
        cls.count = n;
        for (int k = 0; k < STR_DIGITS; k++)
        begin
            cls.digits[k*DIGIT_W +: DIGIT_W] = sat_digit(digit_string[k*DIGIT_W +: DIGIT_W]);
        end
    end

    // two-entry command queue
    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign wr_en     = push && !full;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ (cmd_pop && cmd_valid);
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, cmd_pop && cmd_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> hw/rtl/dtp_engine.sv
// back end: walks and extends the trie held in a node row memory
// depends on dtp_pkg and digit_trie_prefix_checker_macros.svh
`include "digit_trie_prefix_checker_macros.svh"
module dtp_engine #(
    parameter int NODE_COUNT = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  dtp_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          res_push,
    output dtp_pkg::res_t res,
    input  logic          res_full
);
    import dtp_pkg::*;

    localparam int AW     = $clog2(NODE_COUNT);
    localparam int LINK_W = RADIX * AW;
    localparam int ROW_W  = LINK_W + 1;
    localparam logic [AW:0] NODES_MAX = (AW+1)'(NODE_COUNT);

    // node rows: ten child links and an end mark
    logic [ROW_W-1:0] node_mem [NODE_COUNT];
    logic [ROW_W-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [ROW_W-1:0] wr_data;

    eng_state_t       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [AW-1:0]    cur_reg, cur_next;
    logic             fresh_reg, fresh_next;
    logic             prefix_reg, prefix_next;
    logic [AW:0]      nodes_used_reg, nodes_used_next;
    logic             root_valid_reg, root_valid_next;
    logic             sticky_reg, sticky_next;

    logic [ROW_W-1:0] row;
    logic [DIGIT_W-1:0] d;
    logic [AW-1:0]    link;
    logic             at_end, mark_hit, pool_full, hit, start;

    // row view of the current node
    always_comb
    begin
        row       = fresh_reg ? '0 : rd_data_reg;
        d         = digit_at(cmd_reg.digits, idx_reg);
        link      = row[d*AW +: AW];
        at_end    = (idx_reg == cmd_reg.count);
        mark_hit  = (idx_reg != '0) && row[ROW_W-1];
        pool_full = (nodes_used_reg >= NODES_MAX);
        start     = cmd_valid && !res_full;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ENG_IDLE:
            begin
                if (start && !cmd.clear)
                begin
                    state_next = ENG_WALK;
                end
            end
            ENG_WALK:
            begin
                if (at_end || (link == '0 && pool_full))
                begin
                    state_next = ENG_IDLE;
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        fresh_next      = fresh_reg;
        prefix_next     = prefix_reg;
        nodes_used_next = nodes_used_reg;
        root_valid_next = root_valid_reg;
        sticky_next     = sticky_reg;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res             = '0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_data         = row;
        hit             = 1'b0;
        case (state_reg)
            ENG_IDLE:
            begin
                if (start)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.clear)
                    begin
                        nodes_used_next = (AW+1)'(1);
                        root_valid_next = 1'b0;
                        sticky_next     = 1'b0;
                        res_push        = 1'b1;
                    end
                    else
                    begin
                        cmd_next    = cmd;
                        idx_next    = '0;
                        cur_next    = '0;
                        fresh_next  = !root_valid_reg;
                        prefix_next = 1'b0;
                    end
                end
            end
            ENG_WALK:
            begin
                if (at_end)
                begin
                    // last node: any child means an earlier number extends this one
                    hit          = prefix_reg || (row[LINK_W-1:0] != '0);
                    wr_en        = 1'b1;
                    wr_data      = row;
                    wr_data[ROW_W-1] = 1'b1;
                    if (cur_reg == '0)
                    begin
                        root_valid_next = 1'b1;
                    end
                    sticky_next      = sticky_reg || hit;
                    res_push         = 1'b1;
                    res.conflict     = hit;
                    res.any_conflict = sticky_reg || hit;
                    res.table_full   = 1'b0;
                end
                else if (link != '0)
                begin
                    // follow an existing child
                    prefix_next = prefix_reg || mark_hit;
                    cur_next    = link;
                    fresh_next  = 1'b0;
                    rd_addr     = link;
                    idx_next    = idx_reg + CNT_W'(1);
                end
                else if (pool_full)
                begin
                    // pool exhausted; a fresh node still needs its empty row stored
                    hit     = prefix_reg || mark_hit;
                    wr_en   = fresh_reg;
                    wr_data = '0;
                    sticky_next      = sticky_reg || hit;
                    res_push         = 1'b1;
                    res.conflict     = hit;
                    res.any_conflict = sticky_reg || hit;
                    res.table_full   = 1'b1;
                end
                else
                begin
                    // allocate a new child node
                    prefix_next = prefix_reg || mark_hit;
                    wr_en       = 1'b1;
                    wr_data     = row;
                    wr_data[d*AW +: AW] = nodes_used_reg[AW-1:0];
                    if (cur_reg == '0)
                    begin
                        root_valid_next = 1'b1;
                    end
                    cur_next        = nodes_used_reg[AW-1:0];
                    fresh_next      = 1'b1;
                    nodes_used_next = nodes_used_reg + (AW+1)'(1);
                    idx_next        = idx_reg + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ENG_IDLE;
            nodes_used_reg <= (AW+1)'(1);
            root_valid_reg <= 1'b0;
            sticky_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nodes_used_reg <= nodes_used_next;
            root_valid_reg <= root_valid_next;
            sticky_reg     <= sticky_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        fresh_reg  <= fresh_next;
        prefix_reg <= prefix_next;
    end

    // node memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= node_mem[rd_addr];
    end

    `DTP_ASSERT_NOW(a_pool_bound, nodes_used_reg <= NODES_MAX && nodes_used_reg != '0)
    `DTP_ASSERT_IMPL(a_push_room, res_push, !res_full)
    `DTP_ASSERT_IMPL(a_idle_no_write, state_reg == ENG_IDLE, !wr_en)
    `DTP_ASSERT_IMPL(a_clear_result, res_push && state_reg == ENG_IDLE, res == '0)

endmodule

>>> hw/rtl/dtp_res_queue.sv
// result queue between the engine and the result side
// depends on dtp_pkg
module dtp_res_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_push,
    input  dtp_pkg::res_t res,
    output logic          res_full,
    input  logic          pop,
    output logic          empty,
    output dtp_pkg::res_t head
);
    import dtp_pkg::*;

    res_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       wr_en, rd_en;

    // two-entry queue
    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head     = slot_reg[rd_ptr_reg];
    assign wr_en    = res_push && !res_full;
    assign rd_en    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

>>> hw/rtl/digit_trie_prefix_checker.sv
// digit trie prefix checker: an insert pops its command, then per digit reads a node row from the
// node memory or allocates a child, and finally writes the end mark unless the node pool runs out
// command and result queues hold two transactions each, so both sides stall independently
// reset empties both queues and the trie (root only, sticky flag low); no clearing pass
// depends on dtp_pkg, dtp_front, dtp_engine and dtp_res_queue
module digit_trie_prefix_checker #(
    parameter int NODE_COUNT = 1024,
    parameter int MAX_DIGITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       req_type,
    input  logic [dtp_pkg::STR_W-1:0]  digit_string,
    input  logic [dtp_pkg::CNT_W-1:0]  num_digits,
    output logic                       empty,
    input  logic                       pop,
    output logic                       conflict,
    output logic                       any_conflict,
    output logic                       table_full
);
    import dtp_pkg::*;

    logic cmd_valid, cmd_pop, res_push, res_full;
    cmd_t cmd;
    res_t res, head;

    // request classification and command queue
    dtp_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .digit_string (digit_string),
        .num_digits   (num_digits),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    // trie walk and update
    dtp_engine #(.NODE_COUNT(NODE_COUNT)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (res),
        .res_full  (res_full)
    );

    // result queue
    dtp_res_queue u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    assign conflict     = head.conflict;
    assign any_conflict = head.any_conflict;
    assign table_full   = head.table_full;

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the digit trie prefix checker
// depends on dtp_pkg and digit_trie_prefix_checker; keeps its own trie to predict results
module tb_top;

    import dtp_pkg::*;

    localparam int NODES   = 1024;
    localparam int DIGMAX  = 10;
    localparam int N_ITEMS = 650;

    typedef struct {
        logic             clear;
        logic [STR_W-1:0] digits;
        logic [CNT_W-1:0] count;
        bit               hold;
    } txn_t;

    typedef struct {
        logic conflict;
        logic any_conflict;
        logic table_full;
    } verdict_t;

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    logic             req_type;
    logic [STR_W-1:0] digit_string;
    logic [CNT_W-1:0] num_digits;
    logic             empty;
    logic             pop;
    logic             conflict;
    logic             any_conflict;
    logic             table_full;

    txn_t     pending_txns[$];
    verdict_t expected_verdicts[$];
    int       total_txns;
    int       accepted;
    int       checked;
    int       mismatches;
    int       conflicts_seen;
    int       full_seen;
    int       clears_sent;
    bit       all_queued;

    // shadow trie
    int unsigned shadow_links[NODES*RADIX];
    bit          shadow_marks[NODES];
    int unsigned shadow_used;
    bit          shadow_sticky;

    digit_trie_prefix_checker #(
        .NODE_COUNT (NODES),
        .MAX_DIGITS (DIGMAX)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .digit_string (digit_string),
        .num_digits   (num_digits),
        .empty        (empty),
        .pop          (pop),
        .conflict     (conflict),
        .any_conflict (any_conflict),
        .table_full   (table_full)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic void trie_empty();
        for (int k = 0; k < NODES*RADIX; k++)
        begin
            shadow_links[k] = 0;
        end
        for (int k = 0; k < NODES; k++)
        begin
            shadow_marks[k] = 1'b0;
        end
        shadow_used   = 1;
        shadow_sticky = 1'b0;
    endfunction

    // walk and insert one number, giving the verdict the block must report
    function automatic verdict_t trie_insert(txn_t t);
        verdict_t    v;
        int unsigned n;
        int unsigned cur;
        int unsigned nxt;
        int unsigned d;
        bit          prefix_seen;
        bit          extends_other;
        bit          pool_out;
        v = '{1'b0, 1'b0, 1'b0};
        if (t.clear == REQ_CLEAR)
        begin
            trie_empty();
            return v;
        end
        prefix_seen   = 1'b0;
        extends_other = 1'b0;
        pool_out      = 1'b0;
        n   = (t.count == 0) ? 1 : ((t.count > DIGMAX) ? DIGMAX : t.count);
        cur = 0;
        for (int i = 0; i < n; i++)
        begin
            d = t.digits[4*i +: 4];
            if (d > 9)
                d = 9;
            nxt = shadow_links[cur*RADIX + d];
            if (nxt == 0)
            begin
                if (shadow_used >= NODES)
                begin
                    pool_out = 1'b1;
                    break;
                end
                nxt = shadow_used;
                shadow_used++;
                for (int k = 0; k < RADIX; k++)
                begin
                    shadow_links[nxt*RADIX + k] = 0;
                end
                shadow_marks[nxt] = 1'b0;
                shadow_links[cur*RADIX + d] = nxt;
            end
            cur = nxt;
            if (i + 1 < n && shadow_marks[cur])
                prefix_seen = 1'b1;
        end
        if (!pool_out)
        begin
            for (int k = 0; k < RADIX; k++)
            begin
                if (shadow_links[cur*RADIX + k] != 0)
                    extends_other = 1'b1;
            end
            shadow_marks[cur] = 1'b1;
        end
        v.conflict = prefix_seen | extends_other;
        if (v.conflict)
            shadow_sticky = 1'b1;
        v.any_conflict = shadow_sticky;
        v.table_full   = pool_out;
        return v;
    endfunction

    function automatic void add_number(logic [STR_W-1:0] digits, logic [CNT_W-1:0] count);
        txn_t t;
        t = '{REQ_INSERT, digits, count, 1'b0};
        pending_txns.insert(pending_txns.size(), t);
        total_txns++;
    endfunction

    function automatic void add_clear(bit hold);
        txn_t t;
        t = '{REQ_CLEAR, STR_W'($urandom) << 8 | STR_W'($urandom), 4'($urandom), hold};
        pending_txns.insert(pending_txns.size(), t);
        total_txns++;
    endfunction

    // random number drawn from a small digit alphabet, so prefixes are common
    function automatic logic [STR_W-1:0] narrow_digits(int unsigned top);
        logic [STR_W-1:0] s;
        s = '0;
        for (int i = 0; i < STR_DIGITS; i++)
        begin
            s[4*i +: 4] = 4'($urandom_range(top));
        end
        return s;
    endfunction

    function automatic logic [STR_W-1:0] wide_digits();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // idle and stall rates move through three phases as transactions are accepted
    function automatic int sender_idle_pct();
        if (accepted < total_txns / 3)
            return 10;
        else if (accepted < 2 * total_txns / 3)
            return 65;
        return 0;
    endfunction

    function automatic int receiver_stall_pct();
        if (accepted < total_txns / 3)
            return 65;
        else if (accepted < 2 * total_txns / 3)
            return 10;
        return 0;
    endfunction

    // stimulus
    initial
    begin
        int kind;
        int len;
        push         = 1'b0;
        req_type     = REQ_INSERT;
        digit_string = '0;
        num_digits   = '0;
        pop          = 1'b0;
        rst_n        = 1'b0;
        all_queued   = 1'b0;
        total_txns   = 0;
        trie_empty();

        // directed: prefixes both ways, duplicates, digit count and nibble saturation
        add_number(40'h21, 4'd2);
        add_number(40'h1, 4'd1);
        add_number(40'h321, 4'd3);
        add_number(40'h21, 4'd2);
        add_number(40'h5, 4'd1);
        add_number(40'h5, 4'd1);
        add_number(40'hF, 4'd0);
        add_number({10{4'hF}}, 4'd15);
        add_number(40'hA7, 4'd11);
        add_clear(1'b0);
        add_number(40'h0, 4'd10);
        add_number({10{4'hF}}, 4'd10);
        add_number(40'h0, 4'd1);
        add_number(40'h8765432190, 4'd12);
        add_number(40'hB6, 4'd13);
        add_number(40'hC6, 4'd14);
        add_clear(1'b1);
        add_number(40'h0, 4'd3);
        add_number(40'h0, 4'd2);

        // random sets: conflict-rich short numbers, pool-filling long ones, and noise
        while (total_txns < N_ITEMS)
        begin
            kind = $urandom_range(9);
            add_clear(kind == 0);
            if (kind < 6)
            begin
                len = $urandom_range(30, 8);
                repeat (len)
                    add_number(narrow_digits($urandom_range(3, 1)), 4'($urandom_range(4, 1)));
            end
            else if (kind < 8)
            begin
                repeat (120)
                    add_number(wide_digits(), 4'd10);
            end
            else
            begin
                repeat (20)
                    add_number(wide_digits(), 4'($urandom));
            end
        end
        all_queued = 1'b1;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        bit   taken;
        bit   next_push;
        txn_t t;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            taken     = push && !full;
            next_push = push && !taken;
            if (taken)
            begin
                expected_verdicts.insert(expected_verdicts.size(),
                                         trie_insert('{req_type, digit_string,
                                                       num_digits, 1'b0}));
                accepted++;
            end
            if (!next_push && pending_txns.size() != 0
                && !(pending_txns[0].hold && expected_verdicts.size() != 0)
                && $urandom_range(99) >= sender_idle_pct())
            begin
                t = pending_txns.pop_front();
                if (t.clear == REQ_CLEAR)
                    clears_sent++;
                req_type     <= t.clear;
                digit_string <= t.digits;
                num_digits   <= t.count;
                next_push = 1'b1;
            end
            push <= next_push;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: %b%b%b",
                                 conflict, any_conflict, table_full);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    checked++;
                    if (conflict)
                        conflicts_seen++;
                    if (table_full)
                        full_seen++;
                    if (conflict !== want.conflict || any_conflict !== want.any_conflict
                        || table_full !== want.table_full)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: conflict/any/full expected %b%b%b got %b%b%b",
                                     checked, want.conflict, want.any_conflict,
                                     want.table_full, conflict, any_conflict, table_full);
                    end
                end
            end
            pop <= ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    // end of run
    initial
    begin
        wait (all_queued && rst_n);
        while (accepted < total_txns || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (30)
            @(posedge clk);
        $display("checked %0d results over %0d clears; %0d conflicts, %0d table-full",
                 checked, clears_sent, conflicts_seen, full_seen);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // timeout
    initial
    begin
        #5000000;
        $display("timeout with %0d results outstanding", expected_verdicts.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
